// ===== sv/fcpcrc_pkg.sv =====
// shared types, constants and crc helper for the framed command parser
package fcpcrc_pkg;

    localparam logic [1:0] CFG_SYNC_VALUE    = 2'd0;
    localparam logic [1:0] CFG_MAX_LENGTH    = 2'd1;
    localparam logic [1:0] CFG_CRC_POLYNOMIAL = 2'd2;
    localparam logic [1:0] CFG_CRC_START     = 2'd3;

    localparam logic [7:0]  SYNC_VALUE_RESET = 8'haa;
    localparam logic [7:0]  MAX_LENGTH_RESET = 8'd100;
    localparam logic [15:0] CRC_POLY_RESET   = 16'h8408;
    localparam logic [15:0] CRC_START_RESET  = 16'h8408;

    typedef logic [1:0] status_t;
    localparam status_t STATUS_OK       = 2'd0;
    localparam status_t STATUS_CRC_ERR  = 2'd1;
    localparam status_t STATUS_TOO_LONG = 2'd2;

    // reflected crc-16, one byte folded lsb first
    function automatic logic [15:0] crc_fold(
        input logic [15:0] acc,
        input logic [7:0]  data,
        input logic [15:0] poly
    );
        logic [15:0] a;
        a = acc ^ {8'h00, data};
        for (int k = 0; k < 8; k++)
        begin
            if (a[0])
            begin
                a = (a >> 1) ^ poly;
            end
            else
            begin
                a = a >> 1;
            end
        end
        return a;
    endfunction

endpackage

// ===== sv/framed_command_parser_crc_check_unit.sv =====
// framed command parser with crc-16 check, top level
//
// input channel (in_valid/in_ready) carries one received byte per request,
// tagged by from_serial. wireless framing: sync, repeat hi, repeat lo,
// length, data. serial framing: length, repeat, data. each source keeps
// its own phase; counters, crc and held bytes are shared.
// every data byte gives one request on the output channel
// (out_valid/out_ready) with its index, the header fields and, on the
// last byte, frame_end and a status (ok, crc error, too long).
// header bytes give no output.
// a data byte shows on the output in the cycle after it is accepted.
// throughput: one byte per cycle; the phase change and the full byte-wide
// crc update sit between the state registers and the output register.
// when the receiver stalls the output register holds and in_ready drops
// until the pending result is taken or taken in the same cycle.
// configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready
// and is meant to be written while the block is idle.
// reset: wireless hunts for sync, serial waits for length, registers
// return to sync 0xaa, limit 100, poly and start 0x8408.
module framed_command_parser_crc_check_unit
    import fcpcrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    input  logic        from_serial,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  payload_byte,
    output logic [7:0]  byte_index,
    output logic        frame_end,
    output logic [1:0]  frame_status,
    output logic [15:0] repeat_total,
    output logic [7:0]  frame_size,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    typedef enum logic [2:0] {
        PH_SYNC   = 3'd0,
        PH_RPT_HI = 3'd1,
        PH_RPT_LO = 3'd2,
        PH_LEN    = 3'd3,
        PH_DATA   = 3'd4
    } phase_t;

    logic [7:0]  sync_value_reg;
    logic [7:0]  max_length_reg;
    logic [15:0] crc_poly_reg;
    logic [15:0] crc_start_reg;

    phase_t      wl_phase_reg, wl_phase_next;
    phase_t      ser_phase_reg, ser_phase_next;
    logic [15:0] repeat_reg, repeat_next;
    logic [7:0]  exp_len_reg, exp_len_next;
    logic [7:0]  count_reg, count_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  held0_reg, held0_next;
    logic [7:0]  held1_reg, held1_next;

    logic        out_valid_reg;
    logic [7:0]  payload_reg;
    logic [7:0]  index_reg;
    logic        end_reg;
    status_t     status_reg;
    logic [15:0] repeat_out_reg;
    logic [7:0]  size_reg;

    logic        accept;
    phase_t      ph;
    phase_t      ph_next;
    logic        emit;
    logic        last;
    status_t     status;
    logic [15:0] crc_folded;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign crc_folded = crc_fold(crc_reg, held1_reg, crc_poly_reg);

    always_comb
    begin
        ph = from_serial ? ser_phase_reg : wl_phase_reg;
        case (ph)
            PH_SYNC, PH_RPT_HI:
            begin
                if (from_serial)
                begin
                    ph = PH_LEN;
                end
            end
            PH_RPT_LO, PH_LEN, PH_DATA:
            begin
            end
            default:
            begin
                ph = from_serial ? PH_LEN : PH_SYNC;
            end
        endcase

        ph_next      = ph;
        repeat_next  = repeat_reg;
        exp_len_next = exp_len_reg;
        count_next   = count_reg;
        crc_next     = crc_reg;
        held0_next   = held0_reg;
        held1_next   = held1_reg;
        emit         = 1'b0;
        last         = 1'b0;
        status       = STATUS_OK;

        case (ph)
            PH_SYNC:
            begin
                if (rx_byte == sync_value_reg)
                begin
                    ph_next = PH_RPT_HI;
                end
            end
            PH_RPT_HI:
            begin
                repeat_next = {rx_byte, 8'h00};
                ph_next     = PH_RPT_LO;
            end
            PH_RPT_LO:
            begin
                if (from_serial)
                begin
                    repeat_next = {8'h00, rx_byte};
                    ph_next     = PH_DATA;
                end
                else
                begin
                    repeat_next = repeat_reg + {8'h00, rx_byte};
                    ph_next     = PH_LEN;
                end
            end
            PH_LEN:
            begin
                exp_len_next = rx_byte;
                if (rx_byte == 8'd0 || rx_byte > max_length_reg)
                begin
                    if (!from_serial)
                    begin
                        ph_next = PH_SYNC;
                    end
                end
                else
                begin
                    count_next = 8'd0;
                    crc_next   = crc_start_reg;
                    held0_next = 8'd0;
                    held1_next = 8'd0;
                    ph_next    = from_serial ? PH_RPT_LO : PH_DATA;
                end
            end
            default:
            begin
                emit       = 1'b1;
                count_next = count_reg + 8'd1;
                last       = (count_next == exp_len_reg);
                if (count_reg >= 8'd2)
                begin
                    crc_next = crc_folded;
                end
                if (last)
                begin
                    if (exp_len_reg < 8'd2 || {rx_byte, held0_reg} != crc_next)
                    begin
                        status = STATUS_CRC_ERR;
                    end
                    else if (exp_len_reg >= max_length_reg)
                    begin
                        status = STATUS_TOO_LONG;
                    end
                    ph_next = from_serial ? PH_LEN : PH_SYNC;
                end
                held1_next = held0_reg;
                held0_next = rx_byte;
            end
        endcase

        wl_phase_next  = wl_phase_reg;
        ser_phase_next = ser_phase_reg;
        if (from_serial)
        begin
            ser_phase_next = ph_next;
        end
        else
        begin
            wl_phase_next = ph_next;
        end
    end

    // control state, configuration and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_value_reg <= SYNC_VALUE_RESET;
            max_length_reg <= MAX_LENGTH_RESET;
            crc_poly_reg   <= CRC_POLY_RESET;
            crc_start_reg  <= CRC_START_RESET;
            wl_phase_reg   <= PH_SYNC;
            ser_phase_reg  <= PH_LEN;
            repeat_reg     <= 16'd0;
            exp_len_reg    <= 8'd0;
            count_reg      <= 8'd0;
            crc_reg        <= CRC_START_RESET;
            held0_reg      <= 8'd0;
            held1_reg      <= 8'd0;
            out_valid_reg  <= 1'b0;
            payload_reg    <= 8'd0;
            index_reg      <= 8'd0;
            end_reg        <= 1'b0;
            status_reg     <= STATUS_OK;
            repeat_out_reg <= 16'd0;
            size_reg       <= 8'd0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SYNC_VALUE:     sync_value_reg <= cfg_data[7:0];
                    CFG_MAX_LENGTH:     max_length_reg <= cfg_data[7:0];
                    CFG_CRC_POLYNOMIAL: crc_poly_reg   <= cfg_data;
                    CFG_CRC_START:      crc_start_reg  <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (accept)
            begin
                wl_phase_reg  <= wl_phase_next;
                ser_phase_reg <= ser_phase_next;
                repeat_reg    <= repeat_next;
                exp_len_reg   <= exp_len_next;
                count_reg     <= count_next;
                crc_reg       <= crc_next;
                held0_reg     <= held0_next;
                held1_reg     <= held1_next;
            end
            if (in_ready)
            begin
                out_valid_reg <= accept && emit;
            end
            if (accept && emit)
            begin
                payload_reg    <= rx_byte;
                index_reg      <= count_reg;
                end_reg        <= last;
                status_reg     <= status;
                repeat_out_reg <= repeat_reg;
                size_reg       <= exp_len_reg;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign payload_byte = payload_reg;
    assign byte_index   = index_reg;
    assign frame_end    = end_reg;
    assign frame_status = status_reg;
    assign repeat_total = repeat_out_reg;
    assign frame_size   = size_reg;

endmodule

// ===== sv/fcpcrc_checker.sv =====
// port-level checker for the framed command parser, bound to the top level
module fcpcrc_checker
    import fcpcrc_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] payload_byte,
    input logic [7:0] byte_index,
    input logic       frame_end,
    input logic [1:0] frame_status,
    input logic [7:0] frame_size
);

    // status only on the closing byte
    a_status_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !frame_end |-> frame_status == STATUS_OK)
        else $error("status without frame end");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> frame_status == STATUS_OK || frame_status == STATUS_CRC_ERR
            || frame_status == STATUS_TOO_LONG)
        else $error("unknown status code");

    // closing byte sits at frame_size - 1
    a_end_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |-> byte_index + 8'd1 == frame_size)
        else $error("frame end at wrong index");

    // an empty output register never blocks the input side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(payload_byte)
            && $stable(byte_index))
        else $error("result changed while stalled");

endmodule

bind framed_command_parser_crc_check_unit fcpcrc_checker u_fcpcrc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .payload_byte (payload_byte),
    .byte_index   (byte_index),
    .frame_end    (frame_end),
    .frame_status (frame_status),
    .frame_size   (frame_size)
);

// ===== dv/fcpcrc_frame_checker.sv =====
// crc helper for stimulus and prediction, plus the frame parser checker module
`timescale 1ns / 100ps

package fcpcrc_tb_pkg;

    // reflected crc-16 over one byte, lsb first
    function automatic logic [15:0] crc16_byte(
        input logic [15:0] acc,
        input logic [7:0]  value,
        input logic [15:0] poly
    );
        logic [15:0] r;
        r = acc ^ {8'h00, value};
        for (int k = 0; k < 8; k++)
        begin
            r = r[0] ? ((r >> 1) ^ poly) : (r >> 1);
        end
        return r;
    endfunction

endpackage

module fcpcrc_frame_checker
    import fcpcrc_pkg::*;
    import fcpcrc_tb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  rx_byte,
    input  logic        from_serial,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  payload_byte,
    input  logic [7:0]  byte_index,
    input  logic        frame_end,
    input  logic [1:0]  frame_status,
    input  logic [15:0] repeat_total,
    input  logic [7:0]  frame_size,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          mismatches,
    output int          pending,
    output int          results_checked,
    output int          ok_ends,
    output int          crc_ends,
    output int          long_ends
);

    typedef enum logic [2:0] {
        SEEK_SYNC = 3'd0,
        RPT_HIGH  = 3'd1,
        RPT_LOW   = 3'd2,
        LENGTH    = 3'd3,
        PAYLOAD   = 3'd4
    } phase_e;

    typedef struct packed {
        logic [7:0]  data;
        logic [7:0]  pos;
        logic        last;
        status_t     status;
        logic [15:0] rpt;
        logic [7:0]  size;
    } data_result_t;

    data_result_t pending_results[$];

    logic [7:0]  sync_r;
    logic [7:0]  max_r;
    logic [15:0] poly_r;
    logic [15:0] start_r;

    phase_e      radio_ph;
    phase_e      serial_ph;
    logic [15:0] rpt_cnt;
    logic [7:0]  len_expect;
    logic [7:0]  rx_count;
    logic [15:0] crc_acc;
    logic [7:0]  held0;
    logic [7:0]  held1;

    phase_e       ph;
    logic [7:0]   nxt;
    logic         fin;
    status_t      st;
    logic [15:0]  got_crc;
    data_result_t exp_r;
    data_result_t got_r;
    int           bad_count;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_r = SYNC_VALUE_RESET;
            max_r = MAX_LENGTH_RESET;
            poly_r = CRC_POLY_RESET;
            start_r = CRC_START_RESET;
            radio_ph = SEEK_SYNC;
            serial_ph = LENGTH;
            rpt_cnt = 16'h0000;
            len_expect = 8'h00;
            rx_count = 8'h00;
            crc_acc = CRC_START_RESET;
            held0 = 8'h00;
            held1 = 8'h00;
            pending_results.delete();
            bad_count = 0;
            pending <= 0;
            mismatches <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got_r = {payload_byte, byte_index, frame_end, frame_status, repeat_total,
                         frame_size};
                results_checked <= results_checked + 1;
                if (frame_end && frame_status == STATUS_OK)
                    ok_ends <= ok_ends + 1;
                else if (frame_end && frame_status == STATUS_CRC_ERR)
                    crc_ends <= crc_ends + 1;
                else if (frame_end && frame_status == STATUS_TOO_LONG)
                    long_ends <= long_ends + 1;
                if (pending_results.size() == 0)
                begin
                    bad_count++;
                    if (bad_count <= 10)
                        $display("unexpected result: byte %02h pos %0d end %0b status %0d",
                                 payload_byte, byte_index, frame_end, frame_status);
                end
                else
                begin
                    exp_r = pending_results.pop_front();
                    if (got_r !== exp_r)
                    begin
                        bad_count++;
                        if (bad_count <= 10)
                        begin
                            $display("mismatch expected: byte %02h pos %0d end %0b status %0d rpt %04h size %0d",
                                     exp_r.data, exp_r.pos, exp_r.last, exp_r.status,
                                     exp_r.rpt, exp_r.size);
                            $display("         actual:   byte %02h pos %0d end %0b status %0d rpt %04h size %0d",
                                     got_r.data, got_r.pos, got_r.last, got_r.status,
                                     got_r.rpt, got_r.size);
                        end
                    end
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SYNC_VALUE:     sync_r = cfg_data[7:0];
                    CFG_MAX_LENGTH:     max_r = cfg_data[7:0];
                    CFG_CRC_POLYNOMIAL: poly_r = cfg_data;
                    CFG_CRC_START:      start_r = cfg_data;
                    default:            ;
                endcase
            end

            if (in_valid && in_ready)
            begin
                ph = from_serial ? serial_ph : radio_ph;
                if (ph > PAYLOAD || (from_serial && (ph == SEEK_SYNC || ph == RPT_HIGH)))
                    ph = from_serial ? LENGTH : SEEK_SYNC;
                case (ph)
                    SEEK_SYNC:
                    begin
                        if (rx_byte == sync_r)
                            ph = RPT_HIGH;
                    end
                    RPT_HIGH:
                    begin
                        rpt_cnt = {rx_byte, 8'h00};
                        ph = RPT_LOW;
                    end
                    RPT_LOW:
                    begin
                        if (from_serial)
                        begin
                            rpt_cnt = {8'h00, rx_byte};
                            ph = PAYLOAD;
                        end
                        else
                        begin
                            rpt_cnt = rpt_cnt + {8'h00, rx_byte};
                            ph = LENGTH;
                        end
                    end
                    LENGTH:
                    begin
                        len_expect = rx_byte;
                        if (rx_byte == 8'h00 || rx_byte > max_r)
                        begin
                            if (!from_serial)
                                ph = SEEK_SYNC;
                        end
                        else
                        begin
                            rx_count = 8'h00;
                            crc_acc = start_r;
                            held0 = 8'h00;
                            held1 = 8'h00;
                            ph = from_serial ? RPT_LOW : PAYLOAD;
                        end
                    end
                    default:
                    begin
                        nxt = rx_count + 8'd1;
                        fin = (nxt == len_expect);
                        st = STATUS_OK;
                        if (rx_count >= 8'd2)
                            crc_acc = crc16_byte(crc_acc, held1, poly_r);
                        if (fin)
                        begin
                            got_crc = {rx_byte, held0};
                            if (len_expect < 8'd2 || got_crc != crc_acc)
                                st = STATUS_CRC_ERR;
                            else if (len_expect >= max_r)
                                st = STATUS_TOO_LONG;
                            ph = from_serial ? LENGTH : SEEK_SYNC;
                        end
                        pending_results.push_back({rx_byte, rx_count, fin, st, rpt_cnt,
                                                   len_expect});
                        held1 = held0;
                        held0 = rx_byte;
                        rx_count = nxt;
                    end
                endcase
                if (from_serial)
                    serial_ph = ph;
                else
                    radio_ph = ph;
            end

            pending <= pending_results.size();
            mismatches <= bad_count;
        end
    end

endmodule

// ===== dv/tb_framed_command_parser_crc_check_unit.sv =====
// top-level testbench for the framed command parser: stimulus, idling phases and verdict
`timescale 1ns / 100ps

module tb_framed_command_parser_crc_check_unit;

    import fcpcrc_pkg::*;
    import fcpcrc_tb_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASE_BYTES = 235;
    localparam int NUM_PHASES  = 6;
    localparam int FULL_FRAME  = 256;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  rx_byte = 8'h00;
    logic        from_serial = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  payload_byte;
    logic [7:0]  byte_index;
    logic        frame_end;
    logic [1:0]  frame_status;
    logic [15:0] repeat_total;
    logic [7:0]  frame_size;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_SYNC_VALUE;
    logic [15:0] cfg_data = 16'h0000;

    int mismatches;
    int pending;
    int results_checked;
    int ok_ends;
    int crc_ends;
    int long_ends;

    logic [7:0]  sync_sh = SYNC_VALUE_RESET;
    logic [7:0]  max_sh = MAX_LENGTH_RESET;
    logic [15:0] poly_sh = CRC_POLY_RESET;
    logic [15:0] start_sh = CRC_START_RESET;

    int idle_pct = 0;
    int stall_pct = 0;
    int bytes_sent = 0;
    int cycle_count = 0;

    framed_command_parser_crc_check_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .from_serial  (from_serial),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .payload_byte (payload_byte),
        .byte_index   (byte_index),
        .frame_end    (frame_end),
        .frame_status (frame_status),
        .repeat_total (repeat_total),
        .frame_size   (frame_size),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    fcpcrc_frame_checker frame_chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .rx_byte         (rx_byte),
        .from_serial     (from_serial),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .payload_byte    (payload_byte),
        .byte_index      (byte_index),
        .frame_end       (frame_end),
        .frame_status    (frame_status),
        .repeat_total    (repeat_total),
        .frame_size      (frame_size),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .pending         (pending),
        .results_checked (results_checked),
        .ok_ends         (ok_ends),
        .crc_ends        (crc_ends),
        .long_ends       (long_ends)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    task automatic send_byte(input logic [7:0] value, input logic ser);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= value;
        from_serial <= ser;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        bytes_sent++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        case (idx)
            CFG_SYNC_VALUE:     sync_sh = value[7:0];
            CFG_MAX_LENGTH:     max_sh = value[7:0];
            CFG_CRC_POLYNOMIAL: poly_sh = value;
            default:            start_sh = value;
        endcase
    endtask

    task automatic configure(input logic [7:0] sync, input logic [7:0] max_len,
                             input logic [15:0] poly, input logic [15:0] start);
        write_reg(CFG_SYNC_VALUE, {8'h00, sync});
        write_reg(CFG_MAX_LENGTH, {8'h00, max_len});
        write_reg(CFG_CRC_POLYNOMIAL, poly);
        write_reg(CFG_CRC_START, start);
        cfg_valid <= 1'b0;
    endtask

    // hold off until every outstanding result has come back
    task automatic drain();
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    // sends the header and the first keep data bytes of a frame
    task automatic send_frame(input logic ser, input int len, input logic [15:0] rpt,
                              input logic corrupt, input int keep);
        logic [7:0]  body [0:255];
        logic [15:0] acc;
        logic        len_ok;
        int          i;
        for (i = 0; i < len; i++)
            body[i] = 8'($urandom);
        if (len >= 2)
        begin
            acc = start_sh;
            for (i = 0; i < len - 2; i++)
                acc = crc16_byte(acc, body[i], poly_sh);
            body[len - 2] = acc[7:0];
            body[len - 1] = acc[15:8];
        end
        if (corrupt && len > 0)
        begin
            i = $urandom_range(len - 1);
            body[i] = body[i] ^ (8'h01 << $urandom_range(7));
        end
        len_ok = (len != 0) && (len <= max_sh);
        if (ser)
        begin
            send_byte(len[7:0], 1'b1);
            if (len_ok)
                send_byte(rpt[7:0], 1'b1);
        end
        else
        begin
            send_byte(sync_sh, 1'b0);
            send_byte(rpt[15:8], 1'b0);
            send_byte(rpt[7:0], 1'b0);
            send_byte(len[7:0], 1'b0);
        end
        if (len_ok)
        begin
            for (i = 0; i < len && i < keep; i++)
                send_byte(body[i], ser);
        end
    endtask

    function automatic int pick_len();
        int hi;
        hi = ($urandom_range(99) < 4) ? int'(max_sh) : ((max_sh < 8'd12) ? int'(max_sh) : 12);
        return $urandom_range(hi, 1);
    endfunction

    function automatic int rejected_len();
        if (max_sh == 8'd255 || $urandom_range(1))
            return 0;
        return $urandom_range(255, int'(max_sh) + 1);
    endfunction

    task automatic random_request();
        int   r;
        int   len;
        logic ser;
        r = $urandom_range(99);
        ser = 1'($urandom_range(1));
        if (r < 68)
        begin
            send_frame(ser, pick_len(), 16'($urandom), $urandom_range(99) < 20, FULL_FRAME);
        end
        else if (r < 78)
        begin
            send_frame(ser, rejected_len(), 16'($urandom), 1'b0, FULL_FRAME);
        end
        else if (r < 91)
        begin
            send_byte(8'($urandom), ser);
        end
        else if (r < 98)
        begin
            len = pick_len();
            send_frame(ser, len, 16'($urandom), 1'b0, $urandom_range(len - 1));
        end
        else
        begin
            drain();
        end
    endtask

    initial
    begin
        int phase_start;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: hunt, good frame, short frame, rejected lengths, crc error
        send_byte(8'h00, 1'b0);
        send_frame(1'b0, 2, 16'hffff, 1'b0, FULL_FRAME);
        send_frame(1'b1, 1, 16'h0000, 1'b0, FULL_FRAME);
        send_byte(8'd0, 1'b1);
        send_byte(8'd101, 1'b1);
        send_frame(1'b0, 255, 16'h0000, 1'b0, FULL_FRAME);
        send_frame(1'b1, 3, 16'h0080, 1'b0, FULL_FRAME);
        send_frame(1'b0, 2, 16'h0001, 1'b1, FULL_FRAME);

        // serial zero length mid frame leaves a stale length, count has to wrap
        send_frame(1'b0, 6, 16'($urandom), 1'b0, 2);
        send_byte(8'h00, 1'b1);
        for (int i = 0; i < 254; i++)
            send_byte(8'($urandom), 1'b0);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p > 0)
            begin
                drain();
                case (p)
                    1:       configure(8'h00, 8'd255, 16'hffff, 16'h0000);
                    2:       configure(8'hff, 8'd1, 16'h0000, 16'hffff);
                    3:       configure(8'($urandom), 8'($urandom_range(20, 2)),
                                       16'($urandom), 16'($urandom));
                    4:       configure(8'($urandom), 8'($urandom_range(64, 3)),
                                       16'($urandom), 16'($urandom));
                    default: configure(SYNC_VALUE_RESET, MAX_LENGTH_RESET, CRC_POLY_RESET,
                                       CRC_START_RESET);
                endcase
            end
            case (p % 4)
                0:
                begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct = 57;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct = 57;
                end
                default:
                begin
                    idle_pct = 30;
                    stall_pct = 30;
                end
            endcase
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
                random_request();
        end

        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending != 0);
        repeat (10) @(posedge clk);

        $display("sent %0d bytes on both sources over %0d register settings, %0d data results",
                 bytes_sent, NUM_PHASES, results_checked);
        $display("frames closed: %0d ok, %0d crc error, %0d too long",
                 ok_ends, crc_ends, long_ends);
        if (mismatches == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
